>>> hw/rtl/pam_pkg.sv
// pam_pkg: shared types and constants for the polynomial add/sub/mul block.
// No dependencies.
package pam_pkg;

    localparam int MAX_DEGREE_DEF = 31;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [1:0] MODE_LOAD_A = 2'd0;
    localparam logic [1:0] MODE_LOAD_B = 2'd1;
    localparam logic [1:0] MODE_RUN    = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_SUB  = 2'd1;
    localparam logic [1:0] OP_MUL  = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    typedef enum logic [1:0] {
        K_LOAD_A,
        K_LOAD_B,
        K_RUN
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  power;
        logic [31:0] coef;
        logic [4:0]  da;
        logic [4:0]  db;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_EMIT,
        S_MUL_ISSUE,
        S_MUL_DRAIN,
        S_MUL_EMIT
    } t_state;

endpackage

>>> hw/rtl/pam_front.sv
// pam_front: accepts input beats, drops meaningless ones, clamps degrees.
// Depends on pam_pkg.
module pam_front #(
    parameter int MAX_DEGREE = pam_pkg::MAX_DEGREE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_mode,
    input  logic [4:0]     i_power,
    input  logic [31:0]    i_coef,
    input  logic [4:0]     i_da,
    input  logic [4:0]     i_db,
    input  logic           i_full,
    output logic           o_push,
    output pam_pkg::t_cmd  o_cmd
);

    logic w_keep;

    function automatic logic [4:0] clamp(input logic [4:0] d);
        clamp = (int'(d) > MAX_DEGREE) ? 5'(MAX_DEGREE) : d;
    endfunction

    always_comb begin
        o_ready = !i_full;
        o_cmd.power = i_power;
        o_cmd.coef  = i_coef;
        o_cmd.da    = clamp(i_da);
        o_cmd.db    = clamp(i_db);
        o_cmd.kind  = pam_pkg::K_RUN;
        w_keep      = 1'b0;
        unique case (i_mode)
            pam_pkg::MODE_LOAD_A: begin
                o_cmd.kind = pam_pkg::K_LOAD_A;
                w_keep     = int'(i_power) <= MAX_DEGREE;
            end
            pam_pkg::MODE_LOAD_B: begin
                o_cmd.kind = pam_pkg::K_LOAD_B;
                w_keep     = int'(i_power) <= MAX_DEGREE;
            end
            pam_pkg::MODE_RUN: begin
                w_keep = 1'b1;
            end
            default: w_keep = 1'b0;
        endcase
        o_push = i_valid && o_ready && w_keep;
    end

endmodule

>>> hw/rtl/pam_fifo.sv
// pam_fifo: short command queue between front and back.
// Depends on pam_pkg.
module pam_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pam_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output pam_pkg::t_cmd  o_cmd
);

    localparam int D  = pam_pkg::QUEUE_DEPTH;
    localparam int IW = $clog2(D);

    pam_pkg::t_cmd   r_q [D];
    logic [IW-1:0]   r_wp, r_rp;
    logic [IW:0]     r_cnt;

    assign o_full  = r_cnt == (IW+1)'(D);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (IW+1)'(i_push) - (IW+1)'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> !o_empty) else $error("count lost a push");
`endif

endmodule

>>> hw/rtl/pam_back.sv
// pam_back: coefficient stores, add/sub walker, multiply-accumulate, output register.
// Depends on pam_pkg.
module pam_back #(
    parameter int MAX_DEGREE = pam_pkg::MAX_DEGREE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_operation,
    input  logic           i_empty,
    input  pam_pkg::t_cmd  i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_coef,
    output logic [5:0]     o_power,
    output logic           o_last
);

    localparam int AW = $clog2(MAX_DEGREE + 1);
    localparam int PW = $clog2(2 * MAX_DEGREE + 1);

    logic [31:0] r_mem_a [MAX_DEGREE+1];
    logic [31:0] r_mem_b [MAX_DEGREE+1];

    pam_pkg::t_state r_state, n_state;
    logic [PW-1:0]   r_p, n_p, r_i, n_i;
    logic [AW-1:0]   r_da, n_da, r_db, n_db;
    logic            r_sub, n_sub;
    logic [31:0]     r_rd_a, r_rd_b, r_prod, r_acc;
    logic            r_s1v, r_s2v;
    logic            w_issue, w_acc_clr, w_emit, w_we_a, w_we_b;
    logic [AW-1:0]   w_ra, w_rb;
    logic [31:0]     w_res;
    logic [PW-1:0]   w_hi, w_pm1, w_top;
    logic            w_slot;

    logic            r_out_v;
    logic [31:0]     r_out_coef;
    logic [5:0]      r_out_pow;
    logic            r_out_last;

    assign o_valid = r_out_v;
    assign o_coef  = r_out_coef;
    assign o_power = r_out_pow;
    assign o_last  = r_out_last;
    assign w_slot  = !r_out_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (w_we_a) r_mem_a[AW'(i_cmd.power)] <= i_cmd.coef;
        if (w_we_b) r_mem_b[AW'(i_cmd.power)] <= i_cmd.coef;
        r_rd_a <= r_mem_a[w_ra];
        r_rd_b <= r_mem_b[w_rb];
        r_prod <= 32'(r_rd_a * r_rd_b);
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_clr)  r_acc <= '0;
        else if (r_s2v) r_acc <= r_acc + r_prod;
    end

    always_comb begin
        w_hi  = (r_p > PW'(r_da)) ? PW'(r_da) : r_p;
        w_pm1 = r_p - 1'b1;
        w_top = (i_cmd.da > i_cmd.db) ? PW'(i_cmd.da) : PW'(i_cmd.db);
        // keep the add/sub read address steady while the output stalls
        if (r_state == pam_pkg::S_ADD_RD || r_state == pam_pkg::S_ADD_EMIT) begin
            w_ra = AW'(r_p);
            w_rb = AW'(r_p);
        end else begin
            w_ra = AW'(r_i);
            w_rb = AW'(r_p - r_i);
        end
        w_res = '0;
        if (r_state == pam_pkg::S_ADD_EMIT) begin
            w_res = r_sub
                ? (((r_p <= PW'(r_da)) ? r_rd_a : 32'd0)
                   - ((r_p <= PW'(r_db)) ? r_rd_b : 32'd0))
                : (((r_p <= PW'(r_da)) ? r_rd_a : 32'd0)
                   + ((r_p <= PW'(r_db)) ? r_rd_b : 32'd0));
        end else begin
            w_res = r_acc;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_p       = r_p;
        n_i       = r_i;
        n_da      = r_da;
        n_db      = r_db;
        n_sub     = r_sub;
        o_pop     = 1'b0;
        w_we_a    = 1'b0;
        w_we_b    = 1'b0;
        w_issue   = 1'b0;
        w_acc_clr = 1'b0;
        w_emit    = 1'b0;
        unique case (r_state)
            pam_pkg::S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_da  = AW'(i_cmd.da);
                    n_db  = AW'(i_cmd.db);
                    unique case (i_cmd.kind)
                        pam_pkg::K_LOAD_A: w_we_a = 1'b1;
                        pam_pkg::K_LOAD_B: w_we_b = 1'b1;
                        pam_pkg::K_RUN: begin
                            if (i_operation == pam_pkg::OP_ADD
                                    || i_operation == pam_pkg::OP_SUB) begin
                                n_sub   = i_operation == pam_pkg::OP_SUB;
                                n_p     = w_top;
                                n_state = pam_pkg::S_ADD_RD;
                            end else if (i_operation == pam_pkg::OP_MUL) begin
                                n_p       = PW'(i_cmd.da) + PW'(i_cmd.db);
                                n_i       = PW'(i_cmd.da);
                                w_acc_clr = 1'b1;
                                n_state   = pam_pkg::S_MUL_ISSUE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            pam_pkg::S_ADD_RD: n_state = pam_pkg::S_ADD_EMIT;
            pam_pkg::S_ADD_EMIT: begin
                if (w_slot) begin
                    w_emit = 1'b1;
                    if (r_p == '0) begin
                        n_state = pam_pkg::S_IDLE;
                    end else begin
                        n_p     = w_pm1;
                        n_state = pam_pkg::S_ADD_RD;
                    end
                end
            end
            pam_pkg::S_MUL_ISSUE: begin
                w_issue = 1'b1;
                if (r_i == w_hi) n_state = pam_pkg::S_MUL_DRAIN;
                else             n_i     = r_i + 1'b1;
            end
            pam_pkg::S_MUL_DRAIN: begin
                if (!r_s1v && !r_s2v) n_state = pam_pkg::S_MUL_EMIT;
            end
            pam_pkg::S_MUL_EMIT: begin
                if (w_slot) begin
                    w_emit = 1'b1;
                    if (r_p == '0) begin
                        n_state = pam_pkg::S_IDLE;
                    end else begin
                        n_p       = w_pm1;
                        n_i       = (w_pm1 > PW'(r_db)) ? w_pm1 - PW'(r_db) : '0;
                        w_acc_clr = 1'b1;
                        n_state   = pam_pkg::S_MUL_ISSUE;
                    end
                end
            end
            default: n_state = pam_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pam_pkg::S_IDLE;
            r_s1v   <= 1'b0;
            r_s2v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1v   <= w_issue;
            r_s2v   <= r_s1v;
            if (w_emit)       r_out_v <= 1'b1;
            else if (i_ready) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p   <= n_p;
        r_i   <= n_i;
        r_da  <= n_da;
        r_db  <= n_db;
        r_sub <= n_sub;
        if (w_emit) begin
            r_out_coef <= w_res;
            r_out_pow  <= 6'(r_p);
            r_out_last <= r_p == '0;
        end
    end

`ifndef SYNTHESIS
    a_last_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_last) |-> r_out_pow == 6'd0) else $error("last not at power 0");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_slot) else $error("result overwritten");
    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pam_pkg::S_MUL_EMIT |-> !r_s1v && !r_s2v)
        else $error("emit before accumulator settled");
`endif

endmodule

>>> hw/rtl/polynomial_add_sub_mul.sv
// polynomial_add_sub_mul: top level, operation register and channel packing.
// Depends on pam_pkg, pam_front, pam_fifo, pam_back.
//
// Input stream: tuser = mode (load A, load B, run). A load beat writes one
// coefficient at the given power in the back end. A run beat emits result
// beats from the highest power down to power zero; tlast marks the
// power-zero beat. Add/subtract handle each result term as a store read,
// then an output. Multiply, per result power p, issues each product term in
// turn to the single multiply-accumulate unit, then drains its pipeline and
// outputs the sum. A four-entry command queue lets the input keep taking
// beats while a run is emitting. The output register holds a result while
// the receiver stalls, and the back end waits on it.
// Reset clears the queue, the control state and the operation register
// (add); coefficient stores are not cleared and must be loaded before use.
// The operation register may only be written while the block is idle.
module polynomial_add_sub_mul #(
    parameter int MAX_DEGREE = pam_pkg::MAX_DEGREE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,       // operation
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,      // power[4:0], coefficient[36:5],
                                           // degree_a[41:37], degree_b[46:42]
    input  logic [1:0]  s_axis_tuser,      // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,      // result_coefficient[31:0], result_power[37:32]
    output logic        m_axis_tlast
);

    logic [1:0]    r_op;
    logic          w_full, w_push, w_pop, w_empty;
    pam_pkg::t_cmd w_in_cmd, w_q_cmd;
    logic [31:0]   w_coef;
    logic [5:0]    w_pow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= pam_pkg::OP_ADD;
        end else if (i_cfg_we) begin
            r_op <= i_cfg_wdata;
        end
    end

    pam_front #(.MAX_DEGREE(MAX_DEGREE)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_mode  (s_axis_tuser),
        .i_power (s_axis_tdata[4:0]),
        .i_coef  (s_axis_tdata[36:5]),
        .i_da    (s_axis_tdata[41:37]),
        .i_db    (s_axis_tdata[46:42]),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_in_cmd)
    );

    pam_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_in_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_q_cmd)
    );

    pam_back #(.MAX_DEGREE(MAX_DEGREE)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_operation (r_op),
        .i_empty     (w_empty),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_coef      (w_coef),
        .o_power     (w_pow),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_pow, w_coef};

endmodule
